FILE: hdl/clm_pkg.sv
// Shared types, character constants and the per-character scan decision for the masker.
package clm_pkg;

	// Character codes that steer the scanner.
	localparam int unsigned CHAR_W = 21;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 21'h00002F;
	localparam logic [CHAR_W-1:0] CH_STAR   = 21'h00002A;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'h000022;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 21'h000027;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h00005C;
	localparam logic [CHAR_W-1:0] CH_LF     = 21'h00000A;
	localparam logic [CHAR_W-1:0] CH_CR     = 21'h00000D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h000020;
	localparam logic [CHAR_W-1:0] CH_NUL    = 21'h000000;

	// Lexical context of the scanner.
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_LINE    = 3'd1,
		MODE_BLOCK   = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_CHARLIT = 3'd4
	} scan_mode_t;

	// Outcome of deciding one character against its lookahead.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		scan_mode_t        mode;
		logic              esc;
		logic              pair;
	} decide_t;

	// One queue entry: the results caused by one input beat.
	typedef struct packed {
		logic [CHAR_W-1:0] ch0;
		logic [CHAR_W-1:0] ch1;
		logic              two;
		logic              done;
	} clm_entry_t;

	// Inside comments and literals only CR and LF survive.
	function automatic logic [CHAR_W-1:0] mask_char(logic [CHAR_W-1:0] ch);
		return (ch == CH_LF || ch == CH_CR) ? ch : CH_SPACE;
	endfunction

	// Decide one character given the next one; updates the mode and escape flag.
	function automatic decide_t decide(scan_mode_t mode, logic esc,
			logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] la);
		decide_t r;
		logic [CHAR_W-1:0] quote;
		r.ch = ch;
		r.mode = mode;
		r.esc = esc;
		r.pair = 1'b0;
		quote = (mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE;
		unique case (mode)
			MODE_LINE: begin
				if (ch == CH_LF || ch == CH_CR) begin
					r.mode = MODE_NORMAL;
				end else begin
					r.ch = CH_SPACE;
				end
			end
			MODE_BLOCK: begin
				if (ch == CH_STAR && la == CH_SLASH) begin
					r.pair = 1'b1;
					r.mode = MODE_NORMAL;
					r.ch = CH_SPACE;
				end else begin
					r.ch = mask_char(ch);
				end
			end
			MODE_STRING, MODE_CHARLIT: begin
				r.ch = mask_char(ch);
				if (esc) begin
					r.esc = 1'b0;
				end else if (ch == CH_BSLASH) begin
					r.esc = 1'b1;
				end else if (ch == quote) begin
					r.mode = MODE_NORMAL;
				end
			end
			default: begin
				// Normal code; unused mode codes behave the same way.
				r.mode = MODE_NORMAL;
				if (ch == CH_SLASH && la == CH_SLASH) begin
					r.pair = 1'b1;
					r.mode = MODE_LINE;
					r.ch = CH_SPACE;
				end else if (ch == CH_SLASH && la == CH_STAR) begin
					r.pair = 1'b1;
					r.mode = MODE_BLOCK;
					r.ch = CH_SPACE;
				end else if (ch == CH_DQUOTE) begin
					r.mode = MODE_STRING;
					r.esc = 1'b0;
					r.ch = CH_SPACE;
				end else if (ch == CH_SQUOTE) begin
					r.mode = MODE_CHARLIT;
					r.esc = 1'b0;
					r.ch = CH_SPACE;
				end
			end
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/c_comment_literal_masker_unit.sv
// Top level of the comment and literal masker.
// Scrubs C/C++ source text one character per beat: comments, string literals and character
// literals come out as spaces with CR and LF kept, and the output text has the same length
// as the input. One input beat is taken every cycle while the internal queue has room
// (QUEUE_DEPTH entries). Because the pairs // and /* need lookahead, each character is held
// until the next one arrives; its result is written to the queue when that next beat is accepted.
// A beat that completes a pair, or ends the text with a character held, yields two output
// beats, one after the other; a beat that only stores a character yields none. The output
// side drains one beat per cycle from the queue while m_tready is high. tlast on the output
// marks the last result of an input beat, tuser marks the final character of the text.
module c_comment_literal_masker_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] char_in, [23:21] zero
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] char_out, [23:21] zero
	output logic        m_tlast,   // run_last
	output logic        m_tuser    // [0] text_done
);

	logic                       push;
	clm_pkg::clm_entry_t        push_entry;
	logic                       full;
	logic                       pop;
	clm_pkg::clm_entry_t        head;
	logic                       empty;
	logic [clm_pkg::CHAR_W-1:0] out_char;

	clm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_char    (s_tdata[clm_pkg::CHAR_W-1:0]),
		.in_eot     (s_tlast),
		.in_ready   (s_tready),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	clm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	clm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (out_char),
		.out_run_last (m_tlast),
		.out_done     (m_tuser)
	);

	// Pad the character to whole bytes.
	assign m_tdata = {3'b000, out_char};

endmodule

FILE: hdl/clm_front.sv
// Front end: accepts characters, runs the scanner and posts results to the queue.
module clm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic [clm_pkg::CHAR_W-1:0]         in_char,
	input  logic                               in_eot,
	output logic                               in_ready,
	output logic                               push,
	output clm_pkg::clm_entry_t                push_entry,
	input  logic                               full
);

	clm_pkg::scan_mode_t               mode_q;
	logic                              esc_q;
	logic [clm_pkg::CHAR_W-1:0]        held_q;
	logic                              held_valid_q;

	clm_pkg::decide_t                  d_held;
	clm_pkg::decide_t                  d_last;
	clm_pkg::scan_mode_t               mode_a;
	logic                              esc_a;
	logic                              pair;
	logic                              accept;

	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	// Decide the held character against the new one, then the new one at end of text.
	always_comb begin
		d_held = clm_pkg::decide(mode_q, esc_q, held_q, in_char);
		mode_a = held_valid_q ? d_held.mode : mode_q;
		esc_a = held_valid_q ? d_held.esc : esc_q;
		pair = held_valid_q && d_held.pair;
		d_last = clm_pkg::decide(mode_a, esc_a, in_char, clm_pkg::CH_NUL);
	end

	// Assemble the queue entry for this beat.
	always_comb begin
		push_entry.ch0 = held_valid_q ? d_held.ch : d_last.ch;
		push_entry.ch1 = pair ? clm_pkg::CH_SPACE : d_last.ch;
		push_entry.two = held_valid_q && (pair || in_eot);
		push_entry.done = in_eot;
		push = accept && (held_valid_q || in_eot);
	end

	// Scanner state; end of text returns everything to the start of a new text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= clm_pkg::MODE_NORMAL;
			esc_q <= 1'b0;
			held_q <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (in_eot) begin
				mode_q <= clm_pkg::MODE_NORMAL;
				esc_q <= 1'b0;
				held_q <= '0;
				held_valid_q <= 1'b0;
			end else begin
				mode_q <= mode_a;
				esc_q <= esc_a;
				held_q <= in_char;
				held_valid_q <= !pair;
			end
		end
	end

endmodule

FILE: hdl/clm_queue.sv
// Small register queue that decouples the scanner from the output side.
module clm_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  clm_pkg::clm_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output clm_pkg::clm_entry_t head,
	output logic                empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	clm_pkg::clm_entry_t  store_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/clm_back.sv
// Back end: unpacks each queue entry into one or two output beats.
module clm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  clm_pkg::clm_entry_t        head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [clm_pkg::CHAR_W-1:0] out_char,
	output logic                       out_run_last,
	output logic                       out_done
);

	logic phase_q;
	logic beat;

	// Present the current half of the head entry.
	always_comb begin
		out_valid = !empty;
		out_char = phase_q ? head.ch1 : head.ch0;
		out_run_last = phase_q || !head.two;
		out_done = head.done && out_run_last;
		beat = out_valid && out_ready;
		pop = beat && out_run_last;
	end

	// Second-beat marker for entries that carry two results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (beat) begin
			phase_q <= !out_run_last;
		end
	end

endmodule

FILE: hdl/clm_checker.sv
// Port-level checks for the masker, bound to the top level.
module clm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// The end-of-text flag only appears on the last result of an input beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("text end flagged on a beat that is not the last of its run");

	// An end-of-text beat accepted while the output is idle yields output, visible in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast && !m_tvalid) |=> m_tvalid)
		else $error("end of text produced no output");

	// Input back-pressure only arises while results are waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with nothing to deliver");

	// A stalled output beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser)))
		else $error("stalled output beat changed");

endmodule

bind c_comment_literal_masker_unit clm_checker u_clm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

FILE: tb/c_comment_literal_masker_unit_tb.sv
// Self-checking testbench for the comment and literal masker: directed rows, then random texts.
`timescale 1ns / 100ps

module c_comment_literal_masker_unit_tb;

	localparam int RANDOM_ITEMS = 255;
	localparam int IDLE_LIMIT = 1000;
	localparam int LONG_HOLD = 120;
	localparam int DRAIN_TEXT = 2;

	// One directed row: the input character, end of text, and an optional typed result.
	typedef struct packed {
		logic [clm_pkg::CHAR_W-1:0] ch;
		logic                       eot;
		logic                       typed;
		logic [1:0]                 cnt;
		logic [clm_pkg::CHAR_W-1:0] e0;
		logic [clm_pkg::CHAR_W-1:0] e1;
	} dir_row_t;

	// One output beat as it should appear on the master side.
	typedef struct packed {
		logic [clm_pkg::CHAR_W-1:0] ch;
		logic                       last;
		logic                       done;
	} out_beat_t;

	typedef enum {
		TOK_WORD,
		TOK_LINE_CMT,
		TOK_BLOCK_CMT,
		TOK_STRING,
		TOK_CHAR,
		TOK_NOISE
	} tok_kind_t;

	// Rows without a typed result are checked against the predictor.
	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{21'h000041, 1'b1, 1'b1, 2'd1, 21'h000041, 21'h0},  // lone 'A' ends a text
		'{21'h1FFFFF, 1'b1, 1'b1, 2'd1, 21'h1FFFFF, 21'h0},  // widest code passes through
		'{clm_pkg::CH_SLASH,  1'b0, 1'b1, 2'd0, 21'h0, 21'h0},  // first char is only held
		'{clm_pkg::CH_SLASH,  1'b1, 1'b1, 2'd2, clm_pkg::CH_SPACE,
			clm_pkg::CH_SPACE},  // '//' right at the end
		'{clm_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 21'h0, 21'h0},  // block comment opens
		'{clm_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{21'h000078,         1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_LF,     1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_STAR,   1'b0, 1'b0, 2'd0, 21'h0, 21'h0},  // block comment closes
		'{clm_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},  // string with escaped quote
		'{clm_pkg::CH_BSLASH, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{21'h000071,         1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_SQUOTE, 1'b1, 1'b0, 2'd0, 21'h0, 21'h0},  // char literal left open
		'{clm_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 21'h0, 21'h0},  // line comment ended by CR
		'{clm_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_CR,     1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{21'h000062,         1'b0, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_SLASH,  1'b1, 1'b0, 2'd0, 21'h0, 21'h0},  // slash sees zero lookahead
		'{clm_pkg::CH_DQUOTE, 1'b0, 1'b0, 2'd0, 21'h0, 21'h0},  // string left open
		'{21'h00007A,         1'b1, 1'b0, 2'd0, 21'h0, 21'h0},
		'{clm_pkg::CH_SLASH,  1'b0, 1'b0, 2'd0, 21'h0, 21'h0},  // real NUL after a slash
		'{clm_pkg::CH_NUL,    1'b1, 1'b0, 2'd0, 21'h0, 21'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	// Predictor state: scanner context, escape flag and the held character.
	clm_pkg::scan_mode_t        txt_mode;
	logic                       txt_esc;
	logic [clm_pkg::CHAR_W-1:0] txt_held;
	logic                       txt_held_v;

	out_beat_t                  masked_q [$];
	out_beat_t                  want;
	logic [clm_pkg::CHAR_W-1:0] text_q [$];

	int n_items = 0;
	int n_texts = 0;
	int n_results = 0;
	int n_errors = 0;
	int idle_cycles = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_done = 1'b0;

	c_comment_literal_masker_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// Inside comments and literals only line breaks survive.
	function automatic logic [clm_pkg::CHAR_W-1:0] keep_breaks(logic [clm_pkg::CHAR_W-1:0] ch);
		return (ch == clm_pkg::CH_LF || ch == clm_pkg::CH_CR) ? ch : clm_pkg::CH_SPACE;
	endfunction

	// Decide one character against its lookahead and advance the scanner context.
	function automatic logic [clm_pkg::CHAR_W-1:0] scrub_one(
			input logic [clm_pkg::CHAR_W-1:0] ch,
			input logic [clm_pkg::CHAR_W-1:0] la, output logic pair);
		logic [clm_pkg::CHAR_W-1:0] quote;
		pair = 1'b0;
		quote = (txt_mode == clm_pkg::MODE_STRING) ? clm_pkg::CH_DQUOTE : clm_pkg::CH_SQUOTE;
		case (txt_mode)
			clm_pkg::MODE_LINE: begin
				if (ch == clm_pkg::CH_LF || ch == clm_pkg::CH_CR) begin
					txt_mode = clm_pkg::MODE_NORMAL;
					return ch;
				end
				return clm_pkg::CH_SPACE;
			end
			clm_pkg::MODE_BLOCK: begin
				if (ch == clm_pkg::CH_STAR && la == clm_pkg::CH_SLASH) begin
					pair = 1'b1;
					txt_mode = clm_pkg::MODE_NORMAL;
					return clm_pkg::CH_SPACE;
				end
				return keep_breaks(ch);
			end
			clm_pkg::MODE_STRING, clm_pkg::MODE_CHARLIT: begin
				if (txt_esc) begin
					txt_esc = 1'b0;
				end else if (ch == clm_pkg::CH_BSLASH) begin
					txt_esc = 1'b1;
				end else if (ch == quote) begin
					txt_mode = clm_pkg::MODE_NORMAL;
				end
				return keep_breaks(ch);
			end
			default: begin
				txt_mode = clm_pkg::MODE_NORMAL;
				if (ch == clm_pkg::CH_SLASH
						&& (la == clm_pkg::CH_SLASH || la == clm_pkg::CH_STAR)) begin
					pair = 1'b1;
					txt_mode = (la == clm_pkg::CH_SLASH) ? clm_pkg::MODE_LINE
						: clm_pkg::MODE_BLOCK;
					return clm_pkg::CH_SPACE;
				end
				if (ch == clm_pkg::CH_DQUOTE || ch == clm_pkg::CH_SQUOTE) begin
					txt_mode = (ch == clm_pkg::CH_DQUOTE) ? clm_pkg::MODE_STRING
						: clm_pkg::MODE_CHARLIT;
					txt_esc = 1'b0;
					return clm_pkg::CH_SPACE;
				end
				return ch;
			end
		endcase
	endfunction

	// Work out the scrubbed characters that one accepted input beat releases.
	task automatic scrub_predict(input logic [clm_pkg::CHAR_W-1:0] ch, input logic eot,
			output int n, output logic [clm_pkg::CHAR_W-1:0] r0,
			output logic [clm_pkg::CHAR_W-1:0] r1);
		logic pair;
		logic tail_pair;
		n = 0;
		pair = 1'b0;
		r0 = '0;
		r1 = '0;
		if (txt_held_v) begin
			r0 = scrub_one(txt_held, ch, pair);
			n = 1;
			txt_held_v = 1'b0;
			if (pair) begin
				r1 = clm_pkg::CH_SPACE;
				n = 2;
			end
		end
		if (!pair) begin
			if (eot) begin
				if (n == 0) begin
					r0 = scrub_one(ch, clm_pkg::CH_NUL, tail_pair);
				end else begin
					r1 = scrub_one(ch, clm_pkg::CH_NUL, tail_pair);
				end
				n++;
			end else begin
				txt_held = ch;
				txt_held_v = 1'b1;
			end
		end
		// The end of a text leaves the scanner ready for a new one.
		if (eot) begin
			txt_mode = clm_pkg::MODE_NORMAL;
			txt_esc = 1'b0;
			txt_held = '0;
			txt_held_v = 1'b0;
		end
	endtask

	// Append one expected output beat.
	task automatic post_beat(input out_beat_t b);
		masked_q.insert(masked_q.size(), b);
	endtask

	// Append one character to the text being built.
	task automatic add_char(input logic [clm_pkg::CHAR_W-1:0] ch);
		text_q.insert(text_q.size(), ch);
	endtask

	// Queue the output beats of one input beat with their last and done flags.
	task automatic queue_masked(input int n, input logic [clm_pkg::CHAR_W-1:0] r0,
			input logic [clm_pkg::CHAR_W-1:0] r1, input logic eot);
		if (n >= 1) begin
			post_beat('{r0, n == 1, eot && n == 1});
		end
		if (n == 2) begin
			post_beat('{r1, 1'b1, eot});
		end
	endtask

	// Offer one character after a random gap and record what it should release.
	task automatic send_item(input logic [clm_pkg::CHAR_W-1:0] ch, input logic eot,
			input logic typed, input logic [1:0] cnt,
			input logic [clm_pkg::CHAR_W-1:0] e0, input logic [clm_pkg::CHAR_W-1:0] e1);
		int gap;
		int n;
		logic [clm_pkg::CHAR_W-1:0] r0;
		logic [clm_pkg::CHAR_W-1:0] r1;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, ch};
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
		scrub_predict(ch, eot, n, r0, r1);
		if (typed) begin
			queue_masked(int'(cnt), e0, e1, eot);
		end else begin
			queue_masked(n, r0, r1, eot);
		end
		n_items++;
		@(negedge clk);
	endtask

	// A lower-case letter.
	function automatic logic [clm_pkg::CHAR_W-1:0] rand_letter();
		return 21'(32'h61 + $urandom_range(0, 25));
	endfunction

	// Any 21-bit code, including values above the Unicode range.
	function automatic logic [clm_pkg::CHAR_W-1:0] rand_wide();
		return 21'($urandom());
	endfunction

	// Any character, biased toward the ones that steer the scanner.
	function automatic logic [clm_pkg::CHAR_W-1:0] any_char();
		case ($urandom_range(0, 11))
			0: return clm_pkg::CH_SLASH;
			1: return clm_pkg::CH_STAR;
			2: return clm_pkg::CH_DQUOTE;
			3: return clm_pkg::CH_SQUOTE;
			4: return clm_pkg::CH_BSLASH;
			5: return clm_pkg::CH_LF;
			6: return clm_pkg::CH_CR;
			7: return clm_pkg::CH_SPACE;
			8: return clm_pkg::CH_NUL;
			9: return rand_wide();
			default: return rand_letter();
		endcase
	endfunction

	// Harmless content: letters, blanks and wide code points.
	function automatic logic [clm_pkg::CHAR_W-1:0] body_char();
		case ($urandom_range(0, 3))
			0, 1: return rand_letter();
			2: return clm_pkg::CH_SPACE;
			default: return rand_wide();
		endcase
	endfunction

	// Append one lexical token to the text being built.
	task automatic add_token();
		tok_kind_t tok;
		tok = tok_kind_t'($urandom_range(0, 5));
		case (tok)
			TOK_WORD: begin
				repeat ($urandom_range(1, 4)) add_char(rand_letter());
			end
			TOK_LINE_CMT: begin
				add_char(clm_pkg::CH_SLASH);
				add_char(clm_pkg::CH_SLASH);
				repeat ($urandom_range(0, 6)) add_char(any_char());
				add_char($urandom_range(0, 1) ? clm_pkg::CH_LF : clm_pkg::CH_CR);
			end
			TOK_BLOCK_CMT: begin
				add_char(clm_pkg::CH_SLASH);
				add_char(clm_pkg::CH_STAR);
				repeat ($urandom_range(0, 8)) add_char(any_char());
				add_char(clm_pkg::CH_STAR);
				add_char(clm_pkg::CH_SLASH);
			end
			TOK_STRING: begin
				add_char(clm_pkg::CH_DQUOTE);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 3) == 0) begin
						add_char(clm_pkg::CH_BSLASH);
						add_char(any_char());
					end else begin
						add_char(body_char());
					end
				end
				add_char(clm_pkg::CH_DQUOTE);
			end
			TOK_CHAR: begin
				add_char(clm_pkg::CH_SQUOTE);
				if ($urandom_range(0, 1)) begin
					add_char(clm_pkg::CH_BSLASH);
					add_char(any_char());
				end else begin
					add_char(body_char());
				end
				add_char(clm_pkg::CH_SQUOTE);
			end
			default: begin
				repeat ($urandom_range(1, 3)) add_char(any_char());
			end
		endcase
	endtask

	// Compare every accepted output beat with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (masked_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected beat: expected none, actual ch=%h last=%b done=%b",
					$time, m_tdata[20:0], m_tlast, m_tuser);
			end else begin
				want = masked_q.pop_front();
				if (m_tdata[20:0] !== want.ch || m_tlast !== want.last || m_tuser !== want.done)
						begin
					n_errors++;
					$display("%0t: mismatch: expected ch=%h last=%b done=%b,",
						$time, want.ch, want.last, want.done);
					$display("    actual ch=%h last=%b done=%b",
						m_tdata[20:0], m_tlast, m_tuser);
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Output side: random hold-offs, bursts, and one long stall while the input keeps coming.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				rx_burst = !rx_burst;
			end
			gap = rx_burst ? 0 : $urandom_range(0, 14);
			if (!hold_done && n_items >= 150) begin
				gap = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Input side: reset, directed rows, then random texts.
	initial begin
		int target;
		txt_mode = clm_pkg::MODE_NORMAL;
		txt_esc = 1'b0;
		txt_held = '0;
		txt_held_v = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_item(DIRECTED[i].ch, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].cnt,
				DIRECTED[i].e0, DIRECTED[i].e1);
			if (DIRECTED[i].eot) begin
				n_texts++;
			end
		end

		// Random texts built from tokens; cutting at the target length leaves some unterminated.
		while (n_items < DIR_ROWS + RANDOM_ITEMS) begin
			text_q.delete();
			target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(4, 36);
			while (text_q.size() < target) begin
				add_token();
			end
			tx_burst = ($urandom_range(0, 3) == 0);
			if (n_texts == DIR_ROWS + DRAIN_TEXT - 17) begin
				// Let the output catch up completely before the next text.
				s_tvalid <= 1'b0;
				do @(negedge clk); while (masked_q.size() != 0);
			end
			for (int k = 0; k < target; k++) begin
				send_item(text_q[k], k == target - 1, 1'b0, 2'd0, '0, '0);
			end
			n_texts++;
		end
		s_tvalid <= 1'b0;

		// Drain, then wait for any stray beat to show up.
		while (masked_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Scrubbed %0d characters in %0d texts and checked %0d output beats.",
			n_items, n_texts, n_results);
		$display("Directed corners, token-built texts, a long output stall and a drain pause.");
		if (n_errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/clm_pkg.sv
hdl/clm_front.sv
hdl/clm_queue.sv
hdl/clm_back.sv
hdl/c_comment_literal_masker_unit.sv
hdl/clm_checker.sv
tb/c_comment_literal_masker_unit_tb.sv
